@@ design/tcst_pkg.sv @@
// Shared constants for the touch contact slot tracker.
package tcst_pkg;

    localparam int SLOT_COUNT_DEFAULT = 10;

    // Bit positions in the contact flags
    localparam int TIP_POS  = 0;
    localparam int INR_POS  = 1;
    localparam int CONF_POS = 2;

    localparam int FLAG_W   = 3;
    localparam int POS_W    = 32;
    localparam int SHAPE_W  = 24;
    localparam int ANGLE_W  = 48;
    localparam int SLOT_W   = FLAG_W + POS_W + SHAPE_W + ANGLE_W;

    localparam int COUNT_W   = 4;
    localparam int COUNT_MAX = 15;

endpackage

@@ design/touch_contact_slot_tracker.sv @@
// Touch contact slot tracker: slot table in one synchronous memory, IDs and flags in flops.
// Update transaction: written back in the cycle after acceptance; busy is high for a single cycle.
// Flush transaction: one record per cycle on rep_strobe, first record on the ports in the
// cycle after the first sweep read; the memory read sweep covers one slot a cycle.
// Reset (rst_n, async, active low) empties every slot and zeroes the touch count at once.
module touch_contact_slot_tracker #(
    parameter int SLOT_COUNT = tcst_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  track_id,
    input  logic [2:0]  contact_flags,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  tip_pressure,
    input  logic [7:0]  contact_width,
    input  logic [7:0]  contact_height,
    input  logic [15:0] azimuth_in,
    input  logic [15:0] altitude_in,
    input  logic [15:0] twist_in,
    output logic        rep_strobe,
    output logic [2:0]  rep_flags,
    output logic [7:0]  rep_id,
    output logic [15:0] rep_x,
    output logic [15:0] rep_y,
    output logic [7:0]  rep_pressure,
    output logic [7:0]  rep_width,
    output logic [7:0]  rep_height,
    output logic [15:0] rep_azimuth,
    output logic [15:0] rep_altitude,
    output logic [15:0] rep_twist,
    output logic [3:0]  touch_count,
    output logic        last_record
);

    localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNTW = $clog2(SLOT_COUNT + 1);
    localparam int SW   = tcst_pkg::SLOT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_UPD   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Slot memory: {angles, shape, position, flags}
    logic [SW-1:0] slot_mem [SLOT_COUNT];
    logic [SW-1:0] rd_data_reg;

    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] tip_reg;
    logic [7:0]            ident_reg [SLOT_COUNT];
    logic [CNTW-1:0]       cnt_reg, cnt_next;

    logic [IDXW-1:0] rd_idx_reg;
    logic [IDXW-1:0] rec_idx_reg;
    logic            rec_used_reg;
    logic            rec_last_reg;
    logic            out_vld_reg;

    // Captured update transaction
    logic [7:0]    in_id_reg;
    logic [SW-1:0] in_word_reg;

    logic            hit;
    logic            any_free;
    logic            alloc;
    logic            wr_en;
    logic [IDXW-1:0] match_idx;
    logic [IDXW-1:0] free_idx;
    logic [IDXW-1:0] wr_addr;
    logic            new_tip;
    logic            old_tip;
    logic            rd_last;
    logic            accept;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign new_tip = in_word_reg[tcst_pkg::TIP_POS];
    assign rd_last = (rd_idx_reg == IDXW'(SLOT_COUNT - 1));

    // Match on used slots and find the lowest free slot
    always_comb
    begin
        hit       = 1'b0;
        any_free  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (used_reg[i] && (ident_reg[i] == in_id_reg))
            begin
                hit       = 1'b1;
                match_idx = IDXW'(i);
            end
            if (!used_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    assign alloc   = (state_reg == ST_UPD) && !hit && new_tip && any_free;
    assign wr_en   = ((state_reg == ST_UPD) && hit) || alloc;
    assign wr_addr = hit ? match_idx : free_idx;
    assign old_tip = hit ? tip_reg[match_idx] : 1'b0;

    // Track the number of touching slots as tips come and go
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            cnt_next = cnt_reg + CNTW'(new_tip) - CNTW'(old_tip);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mode ? ST_FLUSH : ST_UPD;
                end
            end
            ST_UPD:   state_next = ST_IDLE;
            ST_FLUSH:
            begin
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            tip_reg      <= '0;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            out_vld_reg  <= 1'b0;
            rec_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= (state_reg == ST_FLUSH);
            rec_last_reg <= (state_reg == ST_FLUSH) && rd_last;
            if (wr_en)
            begin
                tip_reg[wr_addr] <= new_tip;
            end
            if (alloc)
            begin
                used_reg[free_idx] <= 1'b1;
            end
            // Free untouched slots once the last record has been read out
            if (state_reg == ST_DRAIN)
            begin
                used_reg <= used_reg & tip_reg;
            end
            if (state_reg == ST_FLUSH)
            begin
                rd_idx_reg <= rd_last ? '0 : rd_idx_reg + IDXW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_id_reg   <= track_id;
            in_word_reg <= {twist_in, altitude_in, azimuth_in,
                            contact_height, contact_width, tip_pressure,
                            pos_y, pos_x, contact_flags};
        end
        if (alloc)
        begin
            ident_reg[free_idx] <= in_id_reg;
        end
        if (state_reg == ST_FLUSH)
        begin
            rec_idx_reg  <= rd_idx_reg;
            rec_used_reg <= used_reg[rd_idx_reg];
        end
    end

    // Slot memory port: writes come from updates, reads from the flush sweep only
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= in_word_reg;
        end
        if (state_reg == ST_FLUSH)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg];
        end
    end

    logic [2:0] fb;
    assign fb = rd_data_reg[2:0];

    assign rep_strobe   = out_vld_reg;
    assign last_record  = out_vld_reg && rec_last_reg;
    assign touch_count  = (cnt_reg > CNTW'(tcst_pkg::COUNT_MAX))
                          ? 4'(tcst_pkg::COUNT_MAX) : 4'(cnt_reg);
    assign rep_flags    = rec_used_reg
                          ? {fb[tcst_pkg::CONF_POS] | fb[tcst_pkg::TIP_POS],
                             fb[tcst_pkg::INR_POS], fb[tcst_pkg::TIP_POS]}
                          : 3'd0;
    assign rep_id       = rec_used_reg ? ident_reg[rec_idx_reg] : 8'(rec_idx_reg);
    assign rep_x        = rec_used_reg ? rd_data_reg[18:3]    : 16'd0;
    assign rep_y        = rec_used_reg ? rd_data_reg[34:19]   : 16'd0;
    assign rep_pressure = rec_used_reg ? rd_data_reg[42:35]   : 8'd0;
    assign rep_width    = rec_used_reg ? rd_data_reg[50:43]   : 8'd0;
    assign rep_height   = rec_used_reg ? rd_data_reg[58:51]   : 8'd0;
    assign rep_azimuth  = rec_used_reg ? rd_data_reg[74:59]   : 16'd0;
    assign rep_altitude = rec_used_reg ? rd_data_reg[90:75]   : 16'd0;
    assign rep_twist    = rec_used_reg ? rd_data_reg[106:91]  : 16'd0;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(used_reg & tip_reg))
        else $error("touch count out of step with slot table");

    a_tip_only_used: assert property (@(posedge clk) disable iff (!rst_n)
        (tip_reg & ~used_reg) == '0)
        else $error("tip set on an empty slot");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rep_strobe |-> busy)
        else $error("record strobe outside a flush");

    a_free_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> ((used_reg & ~tip_reg) == '0))
        else $error("released slot still used after flush");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_record |-> (state_reg == ST_DRAIN))
        else $error("last record out of place");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the touch contact slot tracker: directed table, then random traffic.
module testbench;

    localparam int SLOTS      = tcst_pkg::SLOT_COUNT_DEFAULT;
    localparam int CLK_PERIOD = 20;
    localparam int ITEMS_PER_PHASE = 107;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_FLUSH  = 1'b1
    } req_mode_t;

    typedef struct packed {
        req_mode_t   mode;
        logic [7:0]  id;
        logic [2:0]  flags;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  pressure;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] azimuth;
        logic [15:0] altitude;
        logic [15:0] twist;
    } contact_t;

    typedef struct packed {
        logic [2:0]  flags;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  pressure;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] azimuth;
        logic [15:0] altitude;
        logic [15:0] twist;
        logic [3:0]  count;
        logic        last;
    } slot_record_t;

    // want_count / want_flags0 below zero: rely on the slot model alone
    typedef struct packed {
        contact_t item;
        int       want_count;
        int       want_flags0;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [7:0]  track_id;
    logic [2:0]  contact_flags;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  tip_pressure;
    logic [7:0]  contact_width;
    logic [7:0]  contact_height;
    logic [15:0] azimuth_in;
    logic [15:0] altitude_in;
    logic [15:0] twist_in;
    logic        rep_strobe;
    logic [2:0]  rep_flags;
    logic [7:0]  rep_id;
    logic [15:0] rep_x;
    logic [15:0] rep_y;
    logic [7:0]  rep_pressure;
    logic [7:0]  rep_width;
    logic [7:0]  rep_height;
    logic [15:0] rep_azimuth;
    logic [15:0] rep_altitude;
    logic [15:0] rep_twist;
    logic [3:0]  touch_count;
    logic        last_record;

    // Slot table mirror and the records each flush is expected to produce
    logic         slot_taken [SLOTS];
    contact_t     slot_contact [SLOTS];
    slot_record_t flush_records [$];
    int           error_count = 0;

    directed_row_t directed_rows [23] = '{
        '{'{MODE_FLUSH, 8'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, 0, 0},
        '{'{MODE_UPDATE, 8'h00, 3'h7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF}, -1, -1},
        '{'{MODE_UPDATE, 8'hFF, 3'h1, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, -1, -1},
        '{'{MODE_UPDATE, 8'h55, 3'h0, 16'h1234, 16'h5678, 8'h9A, 8'hBC, 8'hDE,
            16'hF0F0, 16'h0F0F, 16'hA5A5}, -1, -1},
        '{'{MODE_UPDATE, 8'h80, 3'h3, 16'h8000, 16'h7FFF, 8'h80, 8'h7F, 8'h01,
            16'h8000, 16'h4000, 16'h0001}, -1, -1},
        '{'{MODE_FLUSH, 8'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, 3, 7},
        '{'{MODE_UPDATE, 8'h00, 3'h2, 16'h0001, 16'h0002, 8'h03, 8'h04, 8'h05,
            16'h0006, 16'h0007, 16'h0008}, -1, -1},
        '{'{MODE_UPDATE, 8'hFF, 3'h4, 16'hFFFE, 16'hFFFD, 8'hFE, 8'hFD, 8'hFC,
            16'hFFFB, 16'hFFFA, 16'hFFF9}, -1, -1},
        // flush fields are don't-care: drive them all high
        '{'{MODE_FLUSH, 8'hFF, 3'h7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, 2},
        '{'{MODE_FLUSH, 8'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, 1, 0},
        '{'{MODE_UPDATE, 8'h10, 3'h1, 16'hA010, 16'hB010, 8'h10, 8'h20, 8'h30,
            16'hC010, 16'hD010, 16'hE010}, -1, -1},
        '{'{MODE_UPDATE, 8'h11, 3'h3, 16'hA011, 16'hB011, 8'h11, 8'h21, 8'h31,
            16'hC011, 16'hD011, 16'hE011}, -1, -1},
        '{'{MODE_UPDATE, 8'h12, 3'h5, 16'hA012, 16'hB012, 8'h12, 8'h22, 8'h32,
            16'hC012, 16'hD012, 16'hE012}, -1, -1},
        '{'{MODE_UPDATE, 8'h13, 3'h7, 16'hA013, 16'hB013, 8'h13, 8'h23, 8'h33,
            16'hC013, 16'hD013, 16'hE013}, -1, -1},
        '{'{MODE_UPDATE, 8'h14, 3'h1, 16'hA014, 16'hB014, 8'h14, 8'h24, 8'h34,
            16'hC014, 16'hD014, 16'hE014}, -1, -1},
        '{'{MODE_UPDATE, 8'h15, 3'h3, 16'hA015, 16'hB015, 8'h15, 8'h25, 8'h35,
            16'hC015, 16'hD015, 16'hE015}, -1, -1},
        '{'{MODE_UPDATE, 8'h16, 3'h5, 16'hA016, 16'hB016, 8'h16, 8'h26, 8'h36,
            16'hC016, 16'hD016, 16'hE016}, -1, -1},
        '{'{MODE_UPDATE, 8'h17, 3'h7, 16'hA017, 16'hB017, 8'h17, 8'h27, 8'h37,
            16'hC017, 16'hD017, 16'hE017}, -1, -1},
        // first of these takes the last free slot; the second is dropped
        '{'{MODE_UPDATE, 8'h18, 3'h1, 16'hA018, 16'hB018, 8'h18, 8'h28, 8'h38,
            16'hC018, 16'hD018, 16'hE018}, -1, -1},
        '{'{MODE_UPDATE, 8'h19, 3'h3, 16'hA019, 16'hB019, 8'h19, 8'h29, 8'h39,
            16'hC019, 16'hD019, 16'hE019}, -1, -1},
        '{'{MODE_FLUSH, 8'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, 10, 5},
        '{'{MODE_UPDATE, 8'h80, 3'h6, 16'h0F0F, 16'hF0F0, 8'h5A, 8'hA5, 8'h3C,
            16'h1111, 16'h2222, 16'h3333}, -1, -1},
        '{'{MODE_FLUSH, 8'h00, 3'h0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
            16'h0000, 16'h0000, 16'h0000}, 9, 5}
    };

    touch_contact_slot_tracker #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .track_id       (track_id),
        .contact_flags  (contact_flags),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .tip_pressure   (tip_pressure),
        .contact_width  (contact_width),
        .contact_height (contact_height),
        .azimuth_in     (azimuth_in),
        .altitude_in    (altitude_in),
        .twist_in       (twist_in),
        .rep_strobe     (rep_strobe),
        .rep_flags      (rep_flags),
        .rep_id         (rep_id),
        .rep_x          (rep_x),
        .rep_y          (rep_y),
        .rep_pressure   (rep_pressure),
        .rep_width      (rep_width),
        .rep_height     (rep_height),
        .rep_azimuth    (rep_azimuth),
        .rep_altitude   (rep_altitude),
        .rep_twist      (rep_twist),
        .touch_count    (touch_count),
        .last_record    (last_record)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Apply one accepted transaction to the slot mirror; a flush queues one record per slot.
    function automatic void track_contact(contact_t c);
        int           hit;
        int           touching;
        slot_record_t rec;
        logic [2:0]   fb;
        if (c.mode == MODE_UPDATE)
        begin
            hit = -1;
            for (int s = 0; s < SLOTS; s++)
                if (hit < 0 && slot_taken[s] && slot_contact[s].id == c.id)
                    hit = s;
            if (hit < 0 && c.flags[tcst_pkg::TIP_POS])
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && !slot_taken[s])
                        hit = s;
            if (hit >= 0)
            begin
                slot_taken[hit]   = 1'b1;
                slot_contact[hit] = c;
            end
        end
        else
        begin
            touching = 0;
            for (int s = 0; s < SLOTS; s++)
                if (slot_taken[s] && slot_contact[s].flags[tcst_pkg::TIP_POS])
                    touching++;
            if (touching > tcst_pkg::COUNT_MAX)
                touching = tcst_pkg::COUNT_MAX;
            for (int s = 0; s < SLOTS; s++)
            begin
                rec = '0;
                if (slot_taken[s])
                begin
                    fb = slot_contact[s].flags;
                    rec.flags[tcst_pkg::TIP_POS]  = fb[tcst_pkg::TIP_POS];
                    rec.flags[tcst_pkg::INR_POS]  = fb[tcst_pkg::INR_POS];
                    rec.flags[tcst_pkg::CONF_POS] = fb[tcst_pkg::TIP_POS]
                                                  | fb[tcst_pkg::CONF_POS];
                    rec.id       = slot_contact[s].id;
                    rec.x        = slot_contact[s].x;
                    rec.y        = slot_contact[s].y;
                    rec.pressure = slot_contact[s].pressure;
                    rec.width    = slot_contact[s].width;
                    rec.height   = slot_contact[s].height;
                    rec.azimuth  = slot_contact[s].azimuth;
                    rec.altitude = slot_contact[s].altitude;
                    rec.twist    = slot_contact[s].twist;
                end
                else
                begin
                    rec.id = 8'(s);
                end
                rec.count = 4'(touching);
                rec.last  = (s == SLOTS - 1);
                flush_records.push_back(rec);
            end
            // drop lifted contacts once reported
            for (int s = 0; s < SLOTS; s++)
                if (slot_taken[s] && !slot_contact[s].flags[tcst_pkg::TIP_POS])
                begin
                    slot_taken[s]   = 1'b0;
                    slot_contact[s] = '0;
                end
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Present one transaction, optionally after random idle cycles, and hold it until taken.
    task automatic send_contact(input contact_t c, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start          = 1'b1;
        mode           = c.mode;
        track_id       = c.id;
        contact_flags  = c.flags;
        pos_x          = c.x;
        pos_y          = c.y;
        tip_pressure   = c.pressure;
        contact_width  = c.width;
        contact_height = c.height;
        azimuth_in     = c.azimuth;
        altitude_in    = c.altitude;
        twist_in       = c.twist;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        track_contact(c);
    endtask

    task automatic drain_records();
        @(negedge clk);
        start = 1'b0;
        while (flush_records.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        slot_record_t want;
        if (rst_n && rep_strobe)
        begin
            if (flush_records.size() == 0)
            begin
                $error("unexpected record: rep_id %0h", rep_id);
                error_count++;
            end
            else
            begin
                want = flush_records.pop_front();
                check_field("rep_flags", want.flags, rep_flags);
                check_field("rep_id", want.id, rep_id);
                check_field("rep_x", want.x, rep_x);
                check_field("rep_y", want.y, rep_y);
                check_field("rep_pressure", want.pressure, rep_pressure);
                check_field("rep_width", want.width, rep_width);
                check_field("rep_height", want.height, rep_height);
                check_field("rep_azimuth", want.azimuth, rep_azimuth);
                check_field("rep_altitude", want.altitude, rep_altitude);
                check_field("rep_twist", want.twist, rep_twist);
                check_field("touch_count", want.count, touch_count);
                check_field("last_record", want.last, last_record);
            end
        end
    end

    initial
    begin
        contact_t c;
        int       base;
        int       idle_pct [3] = '{36, 58, 0};

        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = MODE_UPDATE;
        track_id       = '0;
        contact_flags  = '0;
        pos_x          = '0;
        pos_y          = '0;
        tip_pressure   = '0;
        contact_width  = '0;
        contact_height = '0;
        azimuth_in     = '0;
        altitude_in    = '0;
        twist_in       = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_taken[s]   = 1'b0;
            slot_contact[s] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_contact(directed_rows[i].item, 0);
            if (directed_rows[i].item.mode == MODE_FLUSH)
            begin
                // the records of this flush are the last SLOTS entries
                base = flush_records.size() - SLOTS;
                if (directed_rows[i].want_count >= 0)
                    for (int k = base; k < flush_records.size(); k++)
                        flush_records[k].count = 4'(directed_rows[i].want_count);
                if (directed_rows[i].want_flags0 >= 0)
                    flush_records[base].flags = 3'(directed_rows[i].want_flags0);
            end
        end
        drain_records();

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                c.mode     = ($urandom_range(7) == 0) ? MODE_FLUSH : MODE_UPDATE;
                // a small ID pool keeps matches and a full table frequent
                c.id       = ($urandom_range(99) < 85) ? 8'($urandom_range(31))
                                                       : 8'($urandom_range(255));
                c.flags    = 3'($urandom_range(7));
                if ($urandom_range(9) < 6)
                    c.flags[tcst_pkg::TIP_POS] = 1'b1;
                c.x        = 16'($urandom);
                c.y        = 16'($urandom);
                c.pressure = 8'($urandom);
                c.width    = 8'($urandom);
                c.height   = 8'($urandom);
                c.azimuth  = 16'($urandom);
                c.altitude = 16'($urandom);
                c.twist    = 16'($urandom);
                send_contact(c, idle_pct[phase]);
            end
            drain_records();
        end

        repeat (SLOTS + 4) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ touch_contact_slot_tracker.f @@
design/tcst_pkg.sv
design/touch_contact_slot_tracker.sv
tb/testbench.sv
